// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define PKD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent holds in the cycle of the antecedent
`define PKD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/pkd_pkg.sv =====
package pkd_pkg;

  localparam int FRAME_PIXELS_DEF = 65536;

  localparam int DIV_STEPS = 2;
  localparam int R_QUO_W   = 32;
  localparam int R_DEN_W   = 17;
  localparam int K_QUO_W   = 16;
  localparam int K_DEN_W   = 33;

  localparam int PREP_STAGES  = 4;
  localparam int GAIN_STAGES  = 2;
  localparam int BLEND_STAGES = 5;
  localparam int R_DIV_STAGES = R_QUO_W / DIV_STEPS;
  localparam int K_DIV_STAGES = K_QUO_W / DIV_STEPS;
  localparam int LAT = 1 + PREP_STAGES + R_DIV_STAGES + GAIN_STAGES + K_DIV_STAGES
                       + BLEND_STAGES;

  localparam logic [15:0] CFG_RESET = 16'd256;
  localparam logic [16:0] ONE_Q16   = 17'h10000;
  localparam logic [15:0] HALF_Q16  = 16'h8000;

  typedef enum logic {
    CFG_PROCESS_NOISE = 1'b0,
    CFG_INIT_NOISE    = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic        init_frame;
    logic [15:0] pixel_index;
    logic [7:0]  raw_pixel;
    logic [15:0] box_mean;
    logic [15:0] bilateral_value;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] denoised_pixel;
  } pixel_out_t;

  typedef struct packed {
    logic [23:0] x;
    logic [31:0] p;
    logic [31:0] r;
    logic [15:0] k;
    logic [15:0] prev;
  } state_t;

  typedef struct packed {
    logic        init;
    logic        inr;
    logic [7:0]  raw;
    logic [15:0] mean;
    logic [15:0] bil;
  } stage_a_t;

  typedef struct packed {
    logic        init;
    logic        inr;
    logic [7:0]  raw;
    logic [15:0] mean;
    logic [15:0] bil;
    logic [23:0] x;
    logic [31:0] p;
  } rdiv_side_t;

  typedef struct packed {
    logic        init;
    logic        inr;
    logic [7:0]  raw;
    logic [15:0] mean;
    logic [15:0] bil;
    logic [23:0] x;
    logic [31:0] p;
    logic [31:0] r;
  } kdiv_side_t;

  typedef struct packed {
    logic       wr;
    logic [7:0] pixel;
    state_t     st;
  } wb_t;

  function automatic logic [31:0] sat32(input logic [63:0] v);
    sat32 = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

endpackage

// ===== design/pkd_stream_if.sv =====
interface pkd_stream_if #(parameter type data_t = logic);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/per_pixel_kalman_denoise_fusion.sv =====
// Each input transfer passes the input register, prep, the r divider, gain, the k divider and blend,
// and then the output register, which holds its result while pixel_out.ready is low.
// Throughput: one pixel per cycle unless the output stalls or a hazard holds the input; the r and k
// dividers are pipelined, two quotient bits per stage. An in-range, non-init pixel index that is
// still in flight (36 stages) holds the input until its earlier write-back lands in the state memory.
// Reset (rst, synchronous): clears all valid bits, config registers go to 256.
`include "assert_macros.svh"

module per_pixel_kalman_denoise_fusion #(
  parameter int FRAME_PIXELS = pkd_pkg::FRAME_PIXELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  pkd_stream_if.sink        pixel_in,
  pkd_stream_if.source      pixel_out,
  input  logic              cfg_we,
  input  pkd_pkg::cfg_idx_t cfg_index,
  input  logic [15:0]       cfg_data
);
  import pkd_pkg::*;

  localparam int ADDR_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

  logic [15:0] q_gain;
  logic [15:0] init_noise;

  logic              en;
  logic              acc;
  logic              hazard;
  logic              need_chk;
  logic              in_inr;
  logic [ADDR_W+15:0] in_ext;
  logic [ADDR_W-1:0] in_addr;

  logic              tag_v   [LAT];
  logic              tag_w   [LAT];
  logic [ADDR_W-1:0] tag_idx [LAT];

  logic      a_v;
  stage_a_t  a_s;
  stage_a_t  a_next;

  logic [$bits(state_t)-1:0] ram_rdata;
  state_t                    ram_st;
  logic                      ram_we;

  logic        prep_v;
  logic [R_DEN_W-1:0] rdiv_rem, rdiv_den;
  logic [R_QUO_W-1:0] rdiv_num, rdiv_quo;
  rdiv_side_t  rdiv_side_in, rdiv_side_out;
  logic        rdiv_v;

  logic        gain_v;
  logic [K_DEN_W-1:0] kdiv_rem, kdiv_den;
  logic [K_QUO_W-1:0] kdiv_num, kdiv_quo;
  kdiv_side_t  kdiv_side_in, kdiv_side_out;
  logic        kdiv_v;

  logic        l_v;
  wb_t         wb;

  logic        out_v;
  pixel_out_t  out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_gain     <= CFG_RESET;
      init_noise <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROCESS_NOISE: q_gain     <= cfg_data;
        CFG_INIT_NOISE:    init_noise <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !out_v || pixel_out.ready;
  assign in_inr   = 32'(pixel_in.data.pixel_index) < 32'(FRAME_PIXELS);
  assign in_ext   = {{ADDR_W{1'b0}}, pixel_in.data.pixel_index};
  assign in_addr  = in_ext[ADDR_W-1:0];
  assign need_chk = in_inr && !pixel_in.data.init_frame;

  always_comb begin
    hazard = 1'b0;
    for (int j = 0; j < LAT; j++) begin
      if (tag_v[j] && tag_w[j] && (tag_idx[j] == in_addr)) begin
        hazard = 1'b1;
      end
    end
    hazard = hazard && need_chk;
  end

  assign pixel_in.ready = en && !hazard;
  assign acc            = pixel_in.valid && pixel_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < LAT; j++) begin
        tag_v[j] <= 1'b0;
      end
    end else if (en) begin
      tag_v[0] <= acc;
      for (int j = 1; j < LAT; j++) begin
        tag_v[j] <= tag_v[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_w[0]   <= in_inr;
      tag_idx[0] <= in_addr;
      for (int j = 1; j < LAT; j++) begin
        tag_w[j]   <= tag_w[j-1];
        tag_idx[j] <= tag_idx[j-1];
      end
    end
  end

  always_comb begin
    a_next.init = pixel_in.data.init_frame;
    a_next.inr  = in_inr;
    a_next.raw  = pixel_in.data.raw_pixel;
    a_next.mean = pixel_in.data.box_mean;
    a_next.bil  = pixel_in.data.bilateral_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_s <= a_next;
    end
  end

  assign ram_we = en && l_v && wb.wr;
  assign ram_st = ram_rdata;

  pkd_ram #(
    .W     ($bits(state_t)),
    .DEPTH (FRAME_PIXELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tag_idx[LAT-1]),
    .wdata (wb.st),
    .re    (en),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  pkd_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (a_v),
    .a         (a_s),
    .st        (ram_st),
    .q_gain    (q_gain),
    .out_valid (prep_v),
    .rem       (rdiv_rem),
    .num       (rdiv_num),
    .den       (rdiv_den),
    .side      (rdiv_side_in)
  );

  pkd_div_pipe #(
    .D_W    (R_DEN_W),
    .Q_W    (R_QUO_W),
    .STEPS  (DIV_STEPS),
    .SIDE_W ($bits(rdiv_side_t))
  ) u_rdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (prep_v),
    .rem_in    (rdiv_rem),
    .num_in    (rdiv_num),
    .den_in    (rdiv_den),
    .side_in   (rdiv_side_in),
    .out_valid (rdiv_v),
    .quo       (rdiv_quo),
    .side_out  (rdiv_side_out)
  );

  pkd_gain u_gain (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (rdiv_v),
    .quo_r     (rdiv_quo),
    .side_in   (rdiv_side_out),
    .out_valid (gain_v),
    .rem       (kdiv_rem),
    .num       (kdiv_num),
    .den       (kdiv_den),
    .side      (kdiv_side_in)
  );

  pkd_div_pipe #(
    .D_W    (K_DEN_W),
    .Q_W    (K_QUO_W),
    .STEPS  (DIV_STEPS),
    .SIDE_W ($bits(kdiv_side_t))
  ) u_kdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (gain_v),
    .rem_in    (kdiv_rem),
    .num_in    (kdiv_num),
    .den_in    (kdiv_den),
    .side_in   (kdiv_side_in),
    .out_valid (kdiv_v),
    .quo       (kdiv_quo),
    .side_out  (kdiv_side_out)
  );

  pkd_blend u_blend (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (kdiv_v),
    .k_in       (kdiv_quo),
    .side_in    (kdiv_side_out),
    .init_noise (init_noise),
    .out_valid  (l_v),
    .wb         (wb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= l_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.denoised_pixel <= wb.pixel;
    end
  end

  assign pixel_out.valid = out_v;
  assign pixel_out.data  = out_data;

  `PKD_ASSERT(a_tag_align, clk, rst, tag_v[LAT-1] == l_v, "tag line out of step with datapath")
  `PKD_ASSERT_IMP(a_no_rw_clash, clk, rst, acc && need_chk && ram_we, tag_idx[LAT-1] != in_addr, "read of a pixel under write-back")
  `PKD_ASSERT_IMP(a_out_src, clk, rst, $rose(out_v), $past(l_v) && $past(en), "result without a finished item")
endmodule

// ===== design/pkd_ram.sv =====
module pkd_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [W-1:0]                            wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [W-1:0]                            rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== design/pkd_div_pipe.sv =====
module pkd_div_pipe #(
  parameter int D_W    = 17,
  parameter int Q_W    = 32,
  parameter int STEPS  = 2,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [D_W-1:0]    rem_in,
  input  logic [Q_W-1:0]    num_in,
  input  logic [D_W-1:0]    den_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [Q_W-1:0]    quo,
  output logic [SIDE_W-1:0] side_out
);
  localparam int NST = Q_W / STEPS;

  logic              vld      [NST];
  logic [D_W-1:0]    rem      [NST];
  logic [D_W-1:0]    den      [NST];
  logic [Q_W-1:0]    nq       [NST];
  logic [SIDE_W-1:0] side     [NST];
  logic              vld_src  [NST];
  logic [D_W-1:0]    rem_src  [NST];
  logic [D_W-1:0]    den_src  [NST];
  logic [Q_W-1:0]    nq_src   [NST];
  logic [SIDE_W-1:0] side_src [NST];
  logic [D_W-1:0]    rem_next [NST];
  logic [Q_W-1:0]    nq_next  [NST];

  for (genvar s = 0; s < NST; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign vld_src[s]  = in_valid;
      assign rem_src[s]  = rem_in;
      assign den_src[s]  = den_in;
      assign nq_src[s]   = num_in;
      assign side_src[s] = side_in;
    end else begin : g_rest
      assign vld_src[s]  = vld[s-1];
      assign rem_src[s]  = rem[s-1];
      assign den_src[s]  = den[s-1];
      assign nq_src[s]   = nq[s-1];
      assign side_src[s] = side[s-1];
    end

    always_comb begin
      logic [D_W-1:0] r;
      logic [Q_W-1:0] q;
      logic [D_W:0]   rx;
      r  = rem_src[s];
      q  = nq_src[s];
      rx = '0;
      for (int i = 0; i < STEPS; i++) begin
        rx = {r, q[Q_W-1]};
        q  = {q[Q_W-2:0], 1'b0};
        if (rx >= {1'b0, den_src[s]}) begin
          rx   = rx - {1'b0, den_src[s]};
          q[0] = 1'b1;
        end
        r = rx[D_W-1:0];
      end
      rem_next[s] = r;
      nq_next[s]  = q;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld_src[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s]  <= rem_next[s];
        nq[s]   <= nq_next[s];
        den[s]  <= den_src[s];
        side[s] <= side_src[s];
      end
    end
  end

  assign out_valid = vld[NST-1];
  assign quo       = nq[NST-1];
  assign side_out  = side[NST-1];
endmodule

// ===== design/pkd_prep.sv =====
module pkd_prep (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  pkd_pkg::stage_a_t             a,
  input  pkd_pkg::state_t               st,
  input  logic [15:0]                   q_gain,
  output logic                          out_valid,
  output logic [pkd_pkg::R_DEN_W-1:0]   rem,
  output logic [pkd_pkg::R_QUO_W-1:0]   num,
  output logic [pkd_pkg::R_DEN_W-1:0]   den,
  output pkd_pkg::rdiv_side_t           side
);
  import pkd_pkg::*;

  logic        b_v, c_v, d_v, e_v;
  stage_a_t    b_a, c_a, d_a;
  logic [23:0] b_x, c_x, d_x;
  logic [31:0] b_p, c_p, d_p;
  logic [15:0] b_d;
  logic [48:0] b_n, c_n, d_n, e_n;
  logic [16:0] b_den, c_den, d_den, e_den;
  logic [31:0] c_d2;
  logic [47:0] d_qd;
  rdiv_side_t  e_side;

  logic [15:0] d_abs;
  logic [16:0] den_b;

  always_comb begin
    d_abs = (st.prev >= a.mean) ? (st.prev - a.mean) : (a.mean - st.prev);
    den_b = ONE_Q16 + 17'(st.k);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      e_v <= 1'b0;
    end else if (en) begin
      b_v <= in_valid;
      c_v <= b_v;
      d_v <= c_v;
      e_v <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_a   <= a;
      b_x   <= st.x;
      b_p   <= st.p;
      b_d   <= d_abs;
      b_n   <= 49'({st.r, 16'h0000}) + 49'(den_b[16:1]);
      b_den <= den_b;

      c_a   <= b_a;
      c_x   <= b_x;
      c_p   <= b_p;
      c_n   <= b_n;
      c_den <= b_den;
      c_d2  <= 32'(b_d) * 32'(b_d);

      d_a   <= c_a;
      d_x   <= c_x;
      d_p   <= c_p;
      d_n   <= c_n;
      d_den <= c_den;
      d_qd  <= 48'(q_gain) * 48'(c_d2);

      e_n         <= d_n;
      e_den       <= d_den;
      e_side.init <= d_a.init;
      e_side.inr  <= d_a.inr;
      e_side.raw  <= d_a.raw;
      e_side.mean <= d_a.mean;
      e_side.bil  <= d_a.bil;
      e_side.x    <= d_x;
      e_side.p    <= sat32(64'(d_p) + ((64'(d_qd) + 64'd128) >> 8));
    end
  end

  assign out_valid = e_v;
  assign rem       = e_n[48:32];
  assign num       = e_n[31:0];
  assign den       = e_den;
  assign side      = e_side;
endmodule

// ===== design/pkd_gain.sv =====
module pkd_gain (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [pkd_pkg::R_QUO_W-1:0]   quo_r,
  input  pkd_pkg::rdiv_side_t           side_in,
  output logic                          out_valid,
  output logic [pkd_pkg::K_DEN_W-1:0]   rem,
  output logic [pkd_pkg::K_QUO_W-1:0]   num,
  output logic [pkd_pkg::K_DEN_W-1:0]   den,
  output pkd_pkg::kdiv_side_t           side
);
  import pkd_pkg::*;

  logic        f_v, g_v;
  rdiv_side_t  f_side;
  logic [31:0] f_r;
  kdiv_side_t  g_side;
  logic [32:0] g_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
      g_v <= 1'b0;
    end else if (en) begin
      f_v <= in_valid;
      g_v <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_side <= side_in;
      f_r    <= sat32(64'(quo_r) + 64'(ONE_Q16));

      g_side.init <= f_side.init;
      g_side.inr  <= f_side.inr;
      g_side.raw  <= f_side.raw;
      g_side.mean <= f_side.mean;
      g_side.bil  <= f_side.bil;
      g_side.x    <= f_side.x;
      g_side.p    <= f_side.p;
      g_side.r    <= f_r;
      g_den       <= 33'(f_side.p) + 33'(f_r);
    end
  end

  assign out_valid = g_v;
  assign rem       = 33'(g_side.p);
  assign num       = '0;
  assign den       = g_den;
  assign side      = g_side;
endmodule

// ===== design/pkd_blend.sv =====
module pkd_blend (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [pkd_pkg::K_QUO_W-1:0] k_in,
  input  pkd_pkg::kdiv_side_t         side_in,
  input  logic [15:0]                 init_noise,
  output logic                        out_valid,
  output pkd_pkg::wb_t                wb
);
  import pkd_pkg::*;

  logic        h_v, i_v, j_v, k_v, l_v;
  kdiv_side_t  h_s;
  logic [15:0] h_k;
  logic [16:0] h_km;
  logic [40:0] h_m1;
  logic [23:0] h_m2;
  logic [48:0] h_m3;

  kdiv_side_t  i_s;
  logic [15:0] i_k;
  logic [16:0] i_km;
  logic [23:0] i_t;
  logic [31:0] i_pn;

  kdiv_side_t  j_s;
  logic [15:0] j_k;
  logic [31:0] j_pn;
  logic [40:0] j_m4;
  logic [31:0] j_m5;

  kdiv_side_t  k_s;
  logic [15:0] k_k;
  logic [31:0] k_pn;
  logic [23:0] k_y;

  wb_t         l_wb;

  logic [16:0] km_next;
  logic [25:0] y_sum;
  logic [8:0]  pix9;
  logic [7:0]  pix_next;
  state_t      st_next;

  always_comb begin
    km_next = ONE_Q16 - 17'(k_in);
    y_sum   = 26'((42'(j_m4) + 42'({j_m5, 8'h00}) + 42'(HALF_Q16)) >> 16);
    pix9    = 9'((25'(k_y) + 25'(HALF_Q16)) >> 16);
    if (k_s.init || !k_s.inr) begin
      pix_next = k_s.raw;
    end else begin
      pix_next = (pix9 > 9'd255) ? 8'd255 : pix9[7:0];
    end
    if (k_s.init) begin
      st_next.x    = {k_s.raw, 16'h0000};
      st_next.p    = 32'(ONE_Q16);
      st_next.r    = {8'h00, init_noise, 8'h00};
      st_next.k    = HALF_Q16;
      st_next.prev = '0;
    end else begin
      st_next.x    = k_y;
      st_next.p    = k_pn;
      st_next.r    = k_s.r;
      st_next.k    = k_k;
      st_next.prev = k_s.mean;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_v <= 1'b0;
      i_v <= 1'b0;
      j_v <= 1'b0;
      k_v <= 1'b0;
      l_v <= 1'b0;
    end else if (en) begin
      h_v <= in_valid;
      i_v <= h_v;
      j_v <= i_v;
      k_v <= j_v;
      l_v <= k_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_s  <= side_in;
      h_k  <= k_in;
      h_km <= km_next;
      h_m1 <= 41'(km_next) * 41'(side_in.x);
      h_m2 <= 24'(k_in) * 24'(side_in.raw);
      h_m3 <= 49'(km_next) * 49'(side_in.p);

      i_s  <= h_s;
      i_k  <= h_k;
      i_km <= h_km;
      i_t  <= 24'((42'(h_m1) + 42'({h_m2, 16'h0000}) + 42'(HALF_Q16)) >> 16);
      i_pn <= 32'((50'(h_m3) + 50'(HALF_Q16)) >> 16);

      j_s  <= i_s;
      j_k  <= i_k;
      j_pn <= i_pn;
      j_m4 <= 41'(i_km) * 41'(i_t);
      j_m5 <= 32'(i_k) * 32'(i_s.bil);

      k_s  <= j_s;
      k_k  <= j_k;
      k_pn <= j_pn;
      k_y  <= (y_sum > 26'hFF_FFFF) ? 24'hFF_FFFF : y_sum[23:0];

      l_wb.wr    <= k_s.inr;
      l_wb.pixel <= pix_next;
      l_wb.st    <= st_next;
    end
  end

  assign out_valid = l_v;
  assign wb        = l_wb;
endmodule
